/* rtl/sci_pkg.sv */
// Shared types and constants for the serial console interface.
package sci_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_POLL  = 2'd3
  } op_e;

  localparam logic [2:0] REG_RX_CSR = 3'd0;
  localparam logic [2:0] REG_RX_BUF = 3'd2;
  localparam logic [2:0] REG_TX_CSR = 3'd4;
  localparam logic [2:0] REG_TX_BUF = 3'd6;

  localparam logic [15:0] RX_CSR_WMASK = 16'h006e;
  localparam logic [15:0] RX_DONE      = 16'h0080;
  localparam logic [15:0] RX_IE        = 16'h0040;
  localparam logic [15:0] TX_READY     = 16'h0080;
  localparam logic [15:0] TX_IE        = 16'h0040;

  localparam logic [6:0] CHAR_CR  = 7'd13;
  localparam logic [6:0] CHAR_DEL = 7'd127;

  localparam logic [7:0] VEC_RX = 8'o060;
  localparam logic [7:0] VEC_TX = 8'o064;

  typedef struct packed {
    op_e         op;
    logic [2:0]  addr;
    logic [15:0] wdata;
    logic [15:0] wmask;
    logic [7:0]  rx_char;
    logic        ack;
  } item_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        tx_valid;
    logic [6:0]  tx_char;
    logic        irq_request;
    logic [7:0]  irq_vector;
    logic        rx_dropped;
  } result_t;

  typedef struct packed {
    logic       nonempty;
    logic       full;
    logic [7:0] front;
  } qstat_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } qctl_t;

endpackage

/* rtl/sci_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sci_rx_queue.sv */
// Receive character queue: RAM storage with a prefetched front entry.
module sci_rx_queue #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  sci_pkg::qctl_t qctl,
  output sci_pkg::qstat_t qstat
);
  import sci_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count;
  logic [7:0]    ram_q;
  logic          bypass_valid;
  logic [7:0]    bypass_data;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_next = qctl.pop  ? ptr_inc(head) : head;
  assign tail_next = qctl.push ? ptr_inc(tail) : tail;

  // Read the next front entry every cycle; a push into that same slot
  // goes around the RAM through the bypass register.
  sci_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (qctl.push),
    .waddr (tail),
    .wdata (qctl.data),
    .raddr (head_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      bypass_valid <= 1'b0;
    end else begin
      head         <= head_next;
      tail         <= tail_next;
      bypass_valid <= qctl.push && (tail == head_next);
      if (qctl.push && !qctl.pop) begin
        count <= count + 1'b1;
      end else if (qctl.pop && !qctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= qctl.data;
  end

  assign qstat.nonempty = (count != '0);
  assign qstat.full     = (count == CW'(DEPTH));
  assign qstat.front    = bypass_valid ? bypass_data : ram_q;

endmodule

/* rtl/sci_regs.sv */
// Register file and per-transaction update logic of the console interface.
module sci_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  sci_pkg::item_t   item,
  input  sci_pkg::qstat_t  qstat,
  output sci_pkg::qctl_t   qctl,
  output sci_pkg::result_t res
);
  import sci_pkg::*;

  logic [15:0] rx_status, rx_status_next;
  logic [15:0] tx_status, tx_status_next;
  logic        tx_irq_pending, tx_irq_pending_next;
  logic        rx_irq_pending, rx_irq_pending_next;
  logic        hold_valid, hold_valid_next;
  logic [7:0]  hold_char, hold_char_next;
  logic [7:0]  last_read_char, last_read_char_next;
  logic        can_fill;
  logic        push_raw, pop_raw;
  logic [15:0] rx_wmask;

  assign can_fill = !hold_valid && qstat.nonempty;
  assign rx_wmask = item.wmask & RX_CSR_WMASK;

  always_comb begin
    rx_status_next      = rx_status;
    tx_status_next      = tx_status;
    tx_irq_pending_next = tx_irq_pending;
    rx_irq_pending_next = rx_irq_pending;
    hold_valid_next     = hold_valid;
    hold_char_next      = hold_char;
    last_read_char_next = last_read_char;
    push_raw            = 1'b0;
    pop_raw             = 1'b0;
    res                 = '0;

    unique case (item.op)
      OP_READ: begin
        unique case (item.addr)
          REG_RX_CSR: begin
            if (can_fill) begin
              pop_raw         = 1'b1;
              hold_char_next  = qstat.front;
              hold_valid_next = 1'b1;
              if ((rx_status & RX_IE) != '0) begin
                rx_irq_pending_next = 1'b1;
              end
            end
            if (hold_valid_next) begin
              rx_status_next = rx_status | RX_DONE;
            end
            res.rdata = rx_status_next;
          end
          REG_RX_BUF: begin
            rx_status_next = rx_status & ~RX_DONE;
            if (can_fill) begin
              pop_raw             = 1'b1;
              hold_char_next      = qstat.front;
              last_read_char_next = qstat.front;
            end else if (hold_valid) begin
              last_read_char_next = hold_char;
            end
            hold_valid_next = 1'b0;
            res.rdata       = {8'h00, last_read_char_next};
          end
          REG_TX_CSR: res.rdata = tx_status;
          default:    res.rdata = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (item.addr)
          REG_RX_CSR: rx_status_next = (rx_status & ~rx_wmask) | (item.wdata & rx_wmask);
          REG_RX_BUF: rx_status_next = rx_status & ~RX_DONE;
          REG_TX_CSR: begin
            tx_status_next = (tx_status & ~item.wmask) |
                             ((item.wdata | TX_READY) & item.wmask);
          end
          REG_TX_BUF: begin
            if ((tx_status & TX_IE) != '0) begin
              tx_irq_pending_next = 1'b1;
            end
            if (item.wdata[6:0] != CHAR_CR && item.wdata[6:0] != CHAR_DEL) begin
              res.tx_valid = 1'b1;
              res.tx_char  = item.wdata[6:0];
            end
          end
          default: ;
        endcase
      end
      OP_RX: begin
        if (qstat.full) begin
          res.rx_dropped = 1'b1;
        end else begin
          push_raw = 1'b1;
        end
      end
      OP_POLL: begin
        if (tx_irq_pending) begin
          tx_irq_pending_next = !item.ack;
          res.irq_request     = 1'b1;
          res.irq_vector      = VEC_TX;
        end else begin
          if (can_fill) begin
            pop_raw         = 1'b1;
            hold_char_next  = qstat.front;
            hold_valid_next = 1'b1;
            if ((rx_status & RX_IE) != '0) begin
              rx_irq_pending_next = 1'b1;
            end
          end
          if (rx_irq_pending_next) begin
            if (item.ack) begin
              rx_irq_pending_next = 1'b0;
            end
            res.irq_request = 1'b1;
            res.irq_vector  = VEC_RX;
          end
        end
      end
      default: ;
    endcase
  end

  assign qctl.push = fire && push_raw;
  assign qctl.pop  = fire && pop_raw;
  assign qctl.data = item.rx_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_status      <= '0;
      tx_status      <= TX_READY;
      tx_irq_pending <= 1'b0;
      rx_irq_pending <= 1'b0;
      hold_valid     <= 1'b0;
      hold_char      <= '0;
      last_read_char <= '0;
    end else if (fire) begin
      rx_status      <= rx_status_next;
      tx_status      <= tx_status_next;
      tx_irq_pending <= tx_irq_pending_next;
      rx_irq_pending <= rx_irq_pending_next;
      hold_valid     <= hold_valid_next;
      hold_char      <= hold_char_next;
      last_read_char <= last_read_char_next;
    end
  end

endmodule

/* rtl/serial_console_interface.sv */
// Top level of the serial console interface: handshake stages around the register logic.
//
// Console serial line interface with four 16-bit registers: receive status
// (offset 0), receive buffer (2), transmit status (4) and transmit buffer (6).
// Each input transaction is a bus read, a masked bus write, an arriving
// keyboard character or an interrupt poll, and produces exactly one result
// transaction. Throughput is one transaction per cycle while out_ready stays
// high; while a result waits, in_ready drops once the input register is full. An
// accepted input waits in the input register and is loaded into the result
// register when that register is free or draining. The rate rests on the
// single register-update step, which reads the oldest queued character from
// a prefetched front register of the receive queue RAM, so a pop can follow
// a pop in the next cycle. Arriving characters beyond RX_QUEUE_DEPTH are
// dropped and flagged with rx_dropped. The queue RAM needs no clearing pass
// after reset; its fill count guards every read. Transmit interrupts (vector
// 064) win over receive interrupts (vector 060).
module serial_console_interface #(
  parameter int RX_QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [2:0]  addr,
  input  logic [15:0] wdata,
  input  logic [15:0] wmask,
  input  logic [7:0]  rx_char,
  input  logic        ack,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rdata,
  output logic        tx_valid,
  output logic [6:0]  tx_char,
  output logic        irq_request,
  output logic [7:0]  irq_vector,
  output logic        rx_dropped
);
  import sci_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    fire;
  result_t res;
  result_t res_q;
  qstat_t  qstat;
  qctl_t   qctl;

  // Advance the held transaction when the result register is free or draining.
  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  // Input register: capture a new transaction, drop the old one once it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op      <= op_e'(op);
      item.addr    <= addr;
      item.wdata   <= wdata;
      item.wmask   <= wmask;
      item.rx_char <= rx_char;
      item.ack     <= ack;
    end
  end

  sci_rx_queue #(.DEPTH(RX_QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .qctl  (qctl),
    .qstat (qstat)
  );

  sci_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (item),
    .qstat (qstat),
    .qctl  (qctl),
    .res   (res)
  );

  // Result register: hold until the consumer takes the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign rdata       = res_q.rdata;
  assign tx_valid    = res_q.tx_valid;
  assign tx_char     = res_q.tx_char;
  assign irq_request = res_q.irq_request;
  assign irq_vector  = res_q.irq_vector;
  assign rx_dropped  = res_q.rx_dropped;

endmodule

/* rtl/sci_checker.sv */
// Port-level checks for the serial console interface, bound to the top level.
module sci_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] rdata,
  input logic        tx_valid,
  input logic [6:0]  tx_char,
  input logic        irq_request,
  input logic [7:0]  irq_vector,
  input logic        rx_dropped
);
  import sci_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(irq_vector))
    else $error("result changed while stalled");

  a_irq_vector: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_request ? (irq_vector == VEC_RX || irq_vector == VEC_TX)
                               : (irq_vector == 8'h00)))
    else $error("interrupt vector does not match request");

  a_tx_filter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_valid ? (tx_char != CHAR_CR && tx_char != CHAR_DEL)
                            : (tx_char == 7'h00)))
    else $error("bad transmitted character");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_dropped |-> rdata == 16'h0000 && !tx_valid && !irq_request)
    else $error("dropped character with other activity");

  a_single_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({rdata != 16'h0000, tx_valid, irq_request, rx_dropped}) <= 1)
    else $error("result mixes several transaction kinds");

endmodule

bind serial_console_interface sci_checker u_sci_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .rdata       (rdata),
  .tx_valid    (tx_valid),
  .tx_char     (tx_char),
  .irq_request (irq_request),
  .irq_vector  (irq_vector),
  .rx_dropped  (rx_dropped)
);

/* tb/sv/serial_console_interface_tb.sv */
// Self-checking testbench for the serial console interface top level.
module serial_console_interface_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sci_pkg::*;

  // Receive queue depth handed to the block; the predictor uses the same bound.
  localparam int QUEUE_DEPTH  = 64;
  // Length of the long receiver hold-off used to back up the block.
  localparam int LONG_STALL   = 200;
  // Cycles with no transaction on either side before the run is abandoned.
  localparam int QUIET_LIMIT  = 2000;
  // Extra cycles after the last result, allowing time for any stray result.
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = 2'd0;
  logic [2:0]  addr = 3'd0;
  logic [15:0] wdata = 16'h0000;
  logic [15:0] wmask = 16'h0000;
  logic [7:0]  rx_char = 8'h00;
  logic        ack = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] rdata;
  logic        tx_valid;
  logic [6:0]  tx_char;
  logic        irq_request;
  logic [7:0]  irq_vector;
  logic        rx_dropped;

  serial_console_interface #(
    .RX_QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .addr       (addr),
    .wdata      (wdata),
    .wmask      (wmask),
    .rx_char    (rx_char),
    .ack        (ack),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rdata      (rdata),
    .tx_valid   (tx_valid),
    .tx_char    (tx_char),
    .irq_request(irq_request),
    .irq_vector (irq_vector),
    .rx_dropped (rx_dropped)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Console register model: mirrors the block's state after reset and is
  // advanced once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [15:0] csr_rx    = 16'h0000;
  logic [15:0] csr_tx    = TX_READY;
  logic        tx_irq    = 1'b0;
  logic        rx_irq    = 1'b0;
  logic        hold_full = 1'b0;
  logic [7:0]  hold_byte = 8'h00;
  logic [7:0]  last_byte = 8'h00;
  logic [7:0]  kbd_fifo[$];

  // Results still owed by the block, oldest first.
  result_t     console_results[$];
  int          mismatch_count = 0;

  // Move the oldest keyboard character into the holding register when it is
  // empty. Only a status read or a poll may raise the receive interrupt.
  function automatic bit fetch_held(bit irq_allowed);
    if (!hold_full && kbd_fifo.size() != 0) begin
      hold_byte = kbd_fifo.pop_front();
      hold_full = 1'b1;
      if (irq_allowed && |(csr_rx & RX_IE))
        rx_irq = 1'b1;
    end
    return hold_full;
  endfunction

  function automatic result_t predict_console(item_t it);
    result_t     r;
    logic [15:0] m;
    logic [6:0]  c;
    r = '0;
    case (it.op)
      OP_READ: begin
        case (it.addr)
          REG_RX_CSR: begin
            if (fetch_held(1'b1))
              csr_rx = csr_rx | RX_DONE;
            r.rdata = csr_rx;
          end
          REG_RX_BUF: begin
            csr_rx = csr_rx & ~RX_DONE;
            if (fetch_held(1'b0)) begin
              last_byte = hold_byte;
              hold_full = 1'b0;
            end
            // An empty buffer repeats the last character delivered.
            r.rdata = {8'h00, last_byte};
          end
          REG_TX_CSR: r.rdata = csr_tx;
          default:    r.rdata = 16'h0000;
        endcase
      end
      OP_WRITE: begin
        case (it.addr)
          REG_RX_CSR: begin
            m = it.wmask & RX_CSR_WMASK;
            csr_rx = (csr_rx & ~m) | (it.wdata & m);
          end
          REG_RX_BUF: csr_rx = csr_rx & ~RX_DONE;
          REG_TX_CSR: csr_tx = (csr_tx & ~it.wmask) | ((it.wdata | TX_READY) & it.wmask);
          REG_TX_BUF: begin
            c = it.wdata[6:0];
            if (|(csr_tx & TX_IE))
              tx_irq = 1'b1;
            // CR and DEL are swallowed, everything else goes to the terminal.
            if (c != CHAR_CR && c != CHAR_DEL) begin
              r.tx_valid = 1'b1;
              r.tx_char  = c;
            end
          end
          default: ;
        endcase
      end
      OP_RX: begin
        if (kbd_fifo.size() >= QUEUE_DEPTH)
          r.rx_dropped = 1'b1;
        else
          kbd_fifo.push_back(it.rx_char);
      end
      default: begin
        // Transmit request wins; the receive side is looked at only without it.
        if (tx_irq) begin
          tx_irq        = !it.ack;
          r.irq_request = 1'b1;
          r.irq_vector  = VEC_TX;
        end else begin
          void'(fetch_held(1'b1));
          if (rx_irq) begin
            if (it.ack)
              rx_irq = 1'b0;
            r.irq_request = 1'b1;
            r.irq_vector  = VEC_RX;
          end
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: bursts of back-to-back transactions separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int stall_req  = 0;
  int stall_seen = 0;

  // Between bursts drop valid for a random gap; some bursts run with no gap.
  task automatic pace();
    int gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one transaction, hold it until accepted, then log what it must produce.
  task automatic issue(op_e o, logic [2:0] a, logic [15:0] d, logic [15:0] m,
                       logic [7:0] c, logic k);
    item_t it;
    it = '{op: o, addr: a, wdata: d, wmask: m, rx_char: c, ack: k};
    in_valid <= 1'b1;
    op       <= it.op;
    addr     <= it.addr;
    wdata    <= it.wdata;
    wmask    <= it.wmask;
    rx_char  <= it.rx_char;
    ack      <= it.ack;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    console_results.push_back(predict_console(it));
    pace();
  endtask

  // Unused fields carry random filler so every input bit toggles.
  task automatic bus_read(logic [2:0] a);
    issue(OP_READ, a, 16'($urandom()), 16'($urandom()), 8'($urandom()),
          1'($urandom_range(0, 1)));
  endtask

  task automatic bus_write(logic [2:0] a, logic [15:0] d, logic [15:0] m);
    issue(OP_WRITE, a, d, m, 8'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  task automatic key_in(logic [7:0] c);
    issue(OP_RX, 3'($urandom_range(0, 7)), 16'($urandom()), 16'($urandom()), c,
          1'($urandom_range(0, 1)));
  endtask

  task automatic poll_irq(logic k);
    issue(OP_POLL, 3'($urandom_range(0, 7)), 16'($urandom()), 16'($urandom()),
          8'($urandom()), k);
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (console_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready follows a pattern of its own, re-chosen whenever the
  // current one runs out (always ready, light or heavy random stalls, a periodic
  // pattern). A request from the stimulus starts one long hold-off.
  // ---------------------------------------------------------------------------
  int unsigned pat_left   = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left  <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left   <= $urandom_range(8, 64);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 1) == 0);
        default: out_ready <= (pat_left[1:0] != 2'd0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: compare each accepted result with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (console_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%t: result transaction with nothing outstanding (rdata %h)",
                   $realtime, rdata);
      end else begin
        want = console_results.pop_front();
        check_field("rdata", want.rdata, rdata);
        check_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid));
        check_field("tx_char", 16'(want.tx_char), 16'(tx_char));
        check_field("irq_request", 16'(want.irq_request), 16'(irq_request));
        check_field("irq_vector", 16'(want.irq_vector), 16'(irq_vector));
        check_field("rx_dropped", 16'(want.rx_dropped), 16'(rx_dropped));
      end
    end
  end

  // Watchdog: abandon the run if neither side moves a transaction for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("[serial_console_interface] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register values straight after reset, including an odd offset.
  task automatic test_reset_values();
    bus_read(REG_RX_CSR);
    bus_read(REG_RX_BUF);
    bus_read(REG_TX_CSR);
    bus_read(REG_TX_BUF);
    bus_read(3'd7);
  endtask

  // Transmit buffer writes with the interrupt enabled: plain, CR, DEL, NUL.
  task automatic test_transmit_path();
    bus_write(REG_TX_CSR, 16'hffff, 16'hffff);
    bus_write(REG_TX_BUF, 16'h0041, 16'hffff);
    bus_write(REG_TX_BUF, 16'hff8d, 16'h0000);
    bus_write(REG_TX_BUF, 16'h007f, 16'hffff);
    bus_write(REG_TX_BUF, 16'hff80, 16'hffff);
    poll_irq(1'b0);
    poll_irq(1'b1);
    bus_write(REG_TX_CSR, 16'h0000, 16'hffff);
  endtask

  // Receive path: extreme characters, interrupt on poll, repeat of last char.
  task automatic test_receive_path();
    bus_write(REG_RX_CSR, 16'hffff, 16'hffff);
    key_in(8'h00);
    key_in(8'hff);
    poll_irq(1'b0);
    poll_irq(1'b1);
    bus_read(REG_RX_CSR);
    bus_read(REG_RX_BUF);
    bus_read(REG_RX_BUF);
    bus_read(REG_RX_BUF);
    bus_write(REG_RX_BUF, 16'hffff, 16'hffff);
    bus_write(3'd3, 16'hffff, 16'hffff);
  endtask

  // Both requests pending: transmit is granted first, then receive.
  task automatic test_irq_priority();
    bus_write(REG_TX_CSR, TX_IE, 16'hffff);
    key_in(8'h55);
    bus_read(REG_RX_CSR);
    bus_write(REG_TX_BUF, 16'h0078, 16'hffff);
    poll_irq(1'b1);
    poll_irq(1'b1);
    bus_write(REG_RX_CSR, 16'h0000, 16'hffff);
  endtask

  // Loose mix of all operations; reads lean toward the receive buffer so the
  // queue drains about as fast as it fills.
  task automatic test_random_traffic(int n);
    int          sel;
    logic [2:0]  a;
    logic [15:0] m;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      a = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                      : {2'($urandom_range(0, 3)), 1'b0};
      if (sel < 40) begin
        if ($urandom_range(0, 1) == 0)
          a = REG_RX_BUF;
        bus_read(a);
      end else if (sel < 70) begin
        case ($urandom_range(0, 3))
          0:       m = 16'hffff;
          1:       m = 16'h0000;
          default: m = 16'($urandom());
        endcase
        bus_write(a, 16'($urandom()), m);
      end else if (sel < 85) begin
        key_in(8'($urandom()));
      end else begin
        poll_irq(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Well-formed driver sequences with random content: a receive session
  // (control write, characters arrive, status / poll / buffer per character) or a
  // transmit session (control write, characters out, poll and acknowledge).
  task automatic test_console_sessions(int n);
    int         k;
    logic [6:0] c;
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        bus_write(REG_RX_CSR, 16'($urandom()),
                  ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'hffff);
        k = $urandom_range(1, 5);
        repeat (k) key_in(8'($urandom()));
        repeat (k) begin
          bus_read(REG_RX_CSR);
          if ($urandom_range(0, 1) == 0)
            poll_irq(1'($urandom_range(0, 1)));
          bus_read(REG_RX_BUF);
        end
        poll_irq(1'b1);
      end else begin
        bus_write(REG_TX_CSR, 16'($urandom()),
                  ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'hffff);
        k = $urandom_range(1, 4);
        repeat (k) begin
          case ($urandom_range(0, 5))
            0:       c = CHAR_CR;
            1:       c = CHAR_DEL;
            default: c = 7'($urandom());
          endcase
          bus_write(REG_TX_BUF, {9'($urandom()), c}, 16'($urandom()));
          if ($urandom_range(0, 2) == 0)
            bus_read(REG_TX_CSR);
        end
        poll_irq(1'($urandom_range(0, 1)));
        poll_irq(1'b1);
      end
    end
  endtask

  // Hold off the receiver while a flood of characters arrives: the block
  // backs up and stalls its input, and the queue overflows. Then drain it.
  task automatic test_queue_overflow();
    stall_req <= stall_req + 1;
    repeat (QUEUE_DEPTH + 6) key_in(8'($urandom()));
    repeat (QUEUE_DEPTH + 4)
      bus_read(($urandom_range(0, 3) == 0) ? REG_RX_CSR : REG_RX_BUF);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_transmit_path();
    test_receive_path();
    test_irq_priority();
    wait_all_results();

    test_random_traffic(200);
    test_queue_overflow();
    wait_all_results();
    test_console_sessions(40);
    test_random_traffic(200);

    // Let the pipeline empty, then allow time for any stray result.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && console_results.size() == 0)
      $display("[serial_console_interface] OK");
    else
      $display("[serial_console_interface] ERROR");
    $finish;
  end

endmodule
